// ===== src/mfh_pkg.sv =====
// shared types and constants for the mqtt fixed header framer
`timescale 1ns / 1ps

package mfh_pkg;

    localparam int unsigned LEN_W         = 28;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned GROUP_W       = 7;
    localparam int unsigned CNT_W         = 3;
    localparam int unsigned MAX_LEN_BYTES = 4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_LEN     = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_kind;

    // framer state carried from one word to the next
    typedef struct packed {
        t_phase             phase;
        logic [LEN_W-1:0]   accum;
        logic [CNT_W-1:0]   count;
        logic [LEN_W-1:0]   left;
    } t_state;

    // one tagged output word
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        t_kind              byte_kind;
        logic               frame_last;
        logic [LEN_W-1:0]   remaining_length;
        logic               malformed;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase: PH_IDLE,
        accum: '0,
        count: '0,
        left:  '0
    };

endpackage

// ===== src/mfh_if.sv =====
// valid/ready channels for incoming bytes and tagged result words
`timescale 1ns / 1ps

interface mfh_byte_if
    import mfh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mfh_res_if
    import mfh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        byte_kind;
    logic              frame_last;
    logic [LEN_W-1:0]  remaining_length;
    logic              malformed;

    modport source (output valid, output out_byte, output byte_kind, output frame_last,
                    output remaining_length, output malformed, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input frame_last,
                    input remaining_length, input malformed, output ready);
endinterface

// ===== src/mfh_step.sv =====
// next-state and result logic for one received byte
`timescale 1ns / 1ps

module mfh_step
    import mfh_pkg::*;
(
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    output t_state            o_state,
    output t_result           o_res
);

    logic [LEN_W-1:0] group_ext;
    logic [LEN_W-1:0] group_placed;
    logic [LEN_W-1:0] accum_upd;
    logic [LEN_W-1:0] left_dec;

    // place the seven value bits by the number of length bytes seen
    assign group_ext = {{(LEN_W-GROUP_W){1'b0}}, i_byte[GROUP_W-1:0]};

    always_comb begin
        unique case (i_state.count[1:0])
            2'd0:    group_placed = group_ext;
            2'd1:    group_placed = group_ext << GROUP_W;
            2'd2:    group_placed = group_ext << (2*GROUP_W);
            default: group_placed = group_ext << (3*GROUP_W);
        endcase
    end

    assign accum_upd = i_state.accum | group_placed;
    assign left_dec  = i_state.left - LEN_W'(1);

    // phase update and word tagging
    always_comb begin
        o_state                = i_state;
        o_res.out_byte         = i_byte;
        o_res.byte_kind        = KIND_TYPE;
        o_res.frame_last       = 1'b0;
        o_res.remaining_length = '0;
        o_res.malformed        = 1'b0;

        unique case (i_state.phase)
            PH_LEN: begin
                o_res.byte_kind = KIND_LEN;
                if (i_state.count >= CNT_W'(MAX_LEN_BYTES)) begin
                    // fifth length byte: abort the packet
                    o_res.frame_last       = 1'b1;
                    o_res.malformed        = 1'b1;
                    o_res.remaining_length = i_state.accum;
                    o_state.phase          = PH_IDLE;
                    o_state.count          = '0;
                    o_state.left           = '0;
                end else begin
                    o_state.accum = accum_upd;
                    o_state.count = i_state.count + CNT_W'(1);
                    if (!i_byte[BYTE_W-1]) begin
                        if (accum_upd == '0) begin
                            // zero length ends the packet here
                            o_res.frame_last = 1'b1;
                            o_state.phase    = PH_IDLE;
                            o_state.count    = '0;
                            o_state.left     = '0;
                        end else begin
                            o_state.phase = PH_PAYLOAD;
                            o_state.left  = accum_upd;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res.byte_kind = KIND_PAYLOAD;
                o_state.left    = left_dec;
                if (left_dec == '0) begin
                    o_res.frame_last       = 1'b1;
                    o_res.remaining_length = i_state.accum;
                    o_state.phase          = PH_IDLE;
                    o_state.count          = '0;
                end
            end
            default: begin
                // packet type byte starts a new length field
                o_state.phase = PH_LEN;
                o_state.accum = '0;
                o_state.count = '0;
                o_state.left  = '0;
            end
        endcase
    end

endmodule

// ===== src/mqtt_fixed_header_framer_core.sv =====
// An accepted byte's tagged word is held at the output from the cycle after it is accepted.
// Throughput: one byte per cycle unless a held word is not taken; the framer state
// updates in a single pass through the step logic between state and result registers.
// The result register frees up in the same cycle its word is taken.
// Reset (synchronous, active low): idle awaiting a packet type byte,
// length and counts cleared, no word held at the output.
`timescale 1ns / 1ps

module mqtt_fixed_header_framer_core
    import mfh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfh_byte_if.sink    i_in,
    mfh_res_if.source   o_out
);

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_valid;
    logic    accept;

    // input taken whenever the result register is empty or draining
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    mfh_step u_step (
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // framer state and output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    // output drive
    assign o_out.valid            = r_valid;
    assign o_out.out_byte         = r_res.out_byte;
    assign o_out.byte_kind        = r_res.byte_kind;
    assign o_out.frame_last       = r_res.frame_last;
    assign o_out.remaining_length = r_res.remaining_length;
    assign o_out.malformed        = r_res.malformed;

    // checks
    a_malformed_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.malformed) |-> (o_out.frame_last &&
            (o_out.byte_kind == KIND_LEN)))
        else $error("malformed word without last mark");

    a_type_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.byte_kind == KIND_TYPE)) |-> !o_out.frame_last)
        else $error("type byte marked last");

    a_type_starts_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_state.phase != PH_LEN) && (r_state.phase != PH_PAYLOAD))
            |=> (r_state.phase == PH_LEN) && (r_state.count == '0))
        else $error("type byte did not open length field");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= CNT_W'(MAX_LEN_BYTES))
        else $error("length byte count overran");

    a_len_zero_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.frame_last) |-> (o_out.remaining_length == '0))
        else $error("length shown on a word that is not last");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the mqtt fixed header framer core
`timescale 1ns / 1ps

module testbench;
    import mfh_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1550;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mfh_byte_if byte_ch ();
    mfh_res_if  word_ch ();

    mqtt_fixed_header_framer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (word_ch.source)
    );

    // framer state as the checker sees it
    t_phase           fr_phase;
    logic [LEN_W-1:0] fr_accum;
    logic [CNT_W-1:0] fr_count;
    logic [LEN_W-1:0] fr_left;

    t_result expected_words[$];
    t_result want;
    int      fail_count  = 0;
    int      words_sent  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // next tagged word for one accepted byte, advancing the framer state
    function automatic t_result frame_step(input logic [BYTE_W-1:0] b);
        t_result          r;
        logic [LEN_W-1:0] grp;
        r = '{out_byte: b, byte_kind: KIND_TYPE, frame_last: 1'b0,
              remaining_length: '0, malformed: 1'b0};
        case (fr_phase)
            PH_LEN: begin
                r.byte_kind = KIND_LEN;
                if (fr_count >= MAX_LEN_BYTES) begin
                    // fifth length byte aborts the packet
                    r.frame_last       = 1'b1;
                    r.malformed        = 1'b1;
                    r.remaining_length = fr_accum;
                    fr_phase = PH_IDLE;
                    fr_count = '0;
                    fr_left  = '0;
                end else begin
                    grp      = LEN_W'(b[GROUP_W-1:0]) << (GROUP_W * fr_count);
                    fr_accum = fr_accum | grp;
                    fr_count = fr_count + 1'b1;
                    if (!b[BYTE_W-1]) begin
                        if (fr_accum == '0) begin
                            r.frame_last = 1'b1;
                            fr_phase = PH_IDLE;
                            fr_count = '0;
                            fr_left  = '0;
                        end else begin
                            fr_phase = PH_PAYLOAD;
                            fr_left  = fr_accum;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                r.byte_kind = KIND_PAYLOAD;
                fr_left = fr_left - 1'b1;
                if (fr_left == '0) begin
                    r.frame_last       = 1'b1;
                    r.remaining_length = fr_accum;
                    fr_phase = PH_IDLE;
                    fr_count = '0;
                end
            end
            default: begin
                r.byte_kind = KIND_TYPE;
                fr_phase = PH_LEN;
                fr_accum = '0;
                fr_count = '0;
                fr_left  = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [LEN_W-1:0] exp_v,
                                        input logic [LEN_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // record accepted bytes and check each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (word_ch.valid && word_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %0h", $time,
                             word_ch.out_byte);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("out_byte", LEN_W'(want.out_byte), LEN_W'(word_ch.out_byte));
                    check_field("byte_kind", LEN_W'(want.byte_kind), LEN_W'(word_ch.byte_kind));
                    check_field("frame_last", LEN_W'(want.frame_last),
                                LEN_W'(word_ch.frame_last));
                    check_field("remaining_length", want.remaining_length,
                                word_ch.remaining_length);
                    check_field("malformed", LEN_W'(want.malformed), LEN_W'(word_ch.malformed));
                end
            end
            if (byte_ch.valid && byte_ch.ready)
                expected_words.push_back(frame_step(byte_ch.in_byte));
        end
    end

    // receiver stalls: always ready, coin toss, mostly stalled, or a fixed rhythm
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       word_ch.ready <= 1'b1;
            1:       word_ch.ready <= 1'($urandom_range(0, 1));
            2:       word_ch.ready <= ($urandom_range(0, 3) == 0);
            default: word_ch.ready <= (stall_tick % 5 != 0);
        endcase
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // send one byte, with bursts and gaps on the sending side
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    // type byte, length field of n_len bytes, then random payload
    task automatic send_packet(input logic [BYTE_W-1:0] ptype, input int unsigned len,
                               input int n_len);
        logic [GROUP_W-1:0] grp;
        send_byte(ptype);
        for (int i = 0; i < n_len; i++) begin
            grp = GROUP_W'(len >> (GROUP_W * i));
            send_byte({(i < n_len - 1), grp});
        end
        for (int unsigned i = 0; i < len; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_zero_length();
        send_byte(8'h30);
        send_byte(8'h00);
    endtask

    task automatic test_short_packet();
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // continuation byte followed by a zero final byte, value still zero
    task automatic test_zero_final_after_cont();
        send_byte(8'h10);
        send_byte(8'h80);
        send_byte(8'h00);
    endtask

    // full four byte length field carrying a small value
    task automatic test_four_byte_length();
        send_byte(8'h82);
        send_byte(8'h83);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h01);
    endtask

    // over-long length field, fifth byte has bit 7 clear
    task automatic test_over_long();
        send_byte(8'h20);
        repeat (4) send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_random_stream();
        int start_count;
        int pick;
        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_packet(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 24), 1);
            end else if (pick < 72) begin
                // padded length field, zero upper groups
                send_packet(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 24),
                            $urandom_range(2, 4));
            end else if (pick < 94) begin
                // over-long length field with random content
                send_byte(BYTE_W'($urandom_range(0, 255)));
                repeat (4) send_byte({1'b1, 7'($urandom_range(0, 127))});
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                send_packet(BYTE_W'($urandom_range(0, 255)), $urandom_range(128, 220),
                            $urandom_range(2, 4));
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        fr_phase = STATE_RESET.phase;
        fr_accum = STATE_RESET.accum;
        fr_count = STATE_RESET.count;
        fr_left  = STATE_RESET.left;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_short_packet();
        test_zero_final_after_cont();
        test_four_byte_length();
        test_over_long();
        test_random_stream();
        byte_ch.valid <= 1'b0;

        // drain outstanding words, then watch for strays
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
